/* hdl/ole_pkg.sv */
// Shared types, codes and constants of the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 64;

  localparam int CMD_W  = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_POP_FRONT = 2'd1,
    CMD_POP_REAR  = 2'd2,
    CMD_SEARCH    = 2'd3
  } ole_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_RANGE     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } ole_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_TAKE,
    S_SCAN,
    S_RESP
  } ole_state_e;

  typedef struct packed {
    ole_cmd_e                cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } ole_req_t;

  typedef struct packed {
    ole_status_e             status;
    logic signed [VAL_W-1:0] removed_value;
    logic [IDX_W-1:0]        found_index;
    logic [LEN_W-1:0]        new_length;
  } ole_rsp_t;

endpackage

/* hdl/ordered_list_engine_top.sv */
// Top level of the ordered list engine: sequencer, entry memory and output register.
//
// Requests arrive on in_valid_i/in_ready_o with in_req_i; each accepted transaction
// gives exactly one result on out_valid_o/out_ready_i with out_rsp_o, in order.
// The entries sit in a ring in one memory with a registered read port, so the
// sequencer touches one entry per cycle. An insert at position p moves each entry
// from the end down to p one place back and then writes the new value; a removal
// reads one entry; a search reads from the front until a hit or the end of the
// list; a request rejected at once (empty, full, bad position) goes straight to
// the result. The next request is taken in the cycle after the result enters the
// output register, so a request is not taken while another is still in work.
// The result register lets a new request start while a result still waits;
// when the receiver stalls with a result held, the following request finishes
// its work and waits for the register to free up.
// Reset empties the list at once; no clearing pass runs, and memory contents
// are never read before being written.
`timescale 1ns / 1ps
module ordered_list_engine_top #(
  parameter int MAX_ENTRIES = ole_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ole_pkg::ole_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ole_pkg::ole_rsp_t out_rsp_o
);
  import ole_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  logic             rsp_valid;
  logic             rsp_ready;
  ole_rsp_t         rsp;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             out_valid_q;
  ole_rsp_t         out_q;

  ole_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  ole_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* hdl/ole_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ole_ctrl.sv */
// Sequencer that runs list requests against the entry memory, one entry per cycle.
`timescale 1ns / 1ps
module ole_ctrl #(
  parameter int MAX_ENTRIES = ole_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ole_pkg::ole_req_t              in_req_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output ole_pkg::ole_rsp_t              rsp_o,
  output logic                           ram_we_o,
  output logic [$clog2(MAX_ENTRIES)-1:0] ram_waddr_o,
  output logic [ole_pkg::VAL_W-1:0]      ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(MAX_ENTRIES)-1:0] ram_raddr_o,
  input  logic [ole_pkg::VAL_W-1:0]      ram_rdata_i
);
  import ole_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  // The list is a ring in memory: logical index i lives at head + i, wrapped.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(idx);
    if (sum >= SW'(MAX_ENTRIES)) begin
      sum = sum - SW'(MAX_ENTRIES);
    end
    return sum[AW-1:0];
  endfunction

  ole_state_e              state_q, state_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  ole_req_t                req_q;
  ole_status_e             status_q, status_d;
  logic signed [VAL_W-1:0] removed_q, removed_d;
  logic [AW-1:0]           found_q, found_d;

  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_idx;
  logic [CW-1:0] pos_c;
  logic          pos_over;
  logic          pos_at_end;
  logic          list_empty;
  logic          list_full;

  assign pos_c      = CW'(req_q.position);
  assign pos_over   = LW'(in_req_i.position) > LW'(count_q);
  assign pos_at_end = LW'(in_req_i.position) == LW'(count_q);
  assign list_empty = (count_q == '0);
  assign list_full  = (count_q == CW'(MAX_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    removed_d   = removed_q;
    found_d     = found_q;
    in_ready_o  = 1'b0;
    rsp_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_wdata_o = ram_rdata_i;
    rd_idx      = idx_q;
    wr_idx      = idx_q + CW'(1);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          removed_d = '0;
          found_d   = '0;
          unique case (in_req_i.cmd)
            CMD_INSERT: begin
              // The position check takes precedence over the full check.
              if (pos_over) begin
                status_d = STAT_RANGE;
                state_d  = S_RESP;
              end else if (list_full) begin
                status_d = STAT_FULL;
                state_d  = S_RESP;
              end else if (pos_at_end) begin
                state_d = S_PUT;
              end else begin
                ram_re_o = 1'b1;
                rd_idx   = count_q - CW'(1);
                idx_d    = count_q - CW'(1);
                state_d  = S_SHIFT;
              end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
              if (list_empty) begin
                status_d  = STAT_EMPTY;
                removed_d = '1;
                state_d   = S_RESP;
              end else begin
                ram_re_o = 1'b1;
                rd_idx   = (in_req_i.cmd == CMD_POP_FRONT) ? '0 : count_q - CW'(1);
                state_d  = S_TAKE;
              end
            end
            CMD_SEARCH: begin
              if (list_empty) begin
                status_d = STAT_EMPTY;
                state_d  = S_RESP;
              end else begin
                ram_re_o = 1'b1;
                rd_idx   = '0;
                idx_d    = '0;
                state_d  = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Move arrived entry idx_q back one; unless at pos_c, fetch the one before.
        ram_we_o = 1'b1;
        wr_idx   = idx_q + CW'(1);
        if (idx_q == pos_c) begin
          state_d = S_PUT;
        end else begin
          ram_re_o = 1'b1;
          rd_idx   = idx_q - CW'(1);
          idx_d    = idx_q - CW'(1);
        end
      end
      S_PUT: begin
        ram_we_o    = 1'b1;
        wr_idx      = pos_c;
        ram_wdata_o = req_q.value;
        count_d     = count_q + CW'(1);
        status_d    = STAT_OK;
        state_d     = S_RESP;
      end
      S_TAKE: begin
        removed_d = ram_rdata_i;
        count_d   = count_q - CW'(1);
        if (req_q.cmd == CMD_POP_FRONT) begin
          head_d = phys(head_q, CW'(1));
        end
        status_d = STAT_OK;
        state_d  = S_RESP;
      end
      S_SCAN: begin
        if (ram_rdata_i == req_q.value) begin
          found_d  = idx_q[AW-1:0];
          status_d = STAT_OK;
          state_d  = S_RESP;
        end else if (idx_q == count_q - CW'(1)) begin
          status_d = STAT_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          ram_re_o = 1'b1;
          rd_idx   = idx_q + CW'(1);
          idx_d    = idx_q + CW'(1);
        end
      end
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_raddr_o = phys(head_q, rd_idx);
  assign ram_waddr_o = phys(head_q, wr_idx);

  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.found_index   = IDX_W'(found_q);
  assign rsp_o.new_length    = LEN_W'(count_q);

endmodule

/* hdl/ole_checker.sv */
// Port-level checks on the ordered list engine and their binding to the top level.
`timescale 1ns / 1ps
module ole_checker #(
  parameter int MAX_ENTRIES = ole_pkg::MAX_ENTRIES_DEFAULT
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ole_pkg::ole_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ole_pkg::ole_rsp_t out_rsp_o
);
  import ole_pkg::*;

  // A waiting request must stay put until the block takes it.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed or dropped while waiting");

  // A stalled result must stay put until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or dropped while stalled");

  // An empty report can only come from a list that holds nothing.
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_EMPTY |-> out_rsp_o.new_length == '0)
    else $error("empty status with a nonzero length");

  // A full report means the list holds its capacity.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_FULL
    |-> out_rsp_o.new_length == LEN_W'(MAX_ENTRIES))
    else $error("full status with a length below capacity");

  // Only a successful search reports a nonzero index.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found_index != '0 |-> out_rsp_o.status == STAT_OK)
    else $error("found index reported without success");

endmodule

bind ordered_list_engine_top ole_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_ole_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);
